// File: rtl/cwvs_pkg.sv
package cwvs_pkg;

    localparam int MAX_HITS = 1024;
    localparam int HIT_AW   = $clog2(MAX_HITS);
    localparam int CNT_W    = HIT_AW + 1;
    localparam int HIT_W    = 32;
    localparam int NUM_W    = 22;
    localparam int STEP_W   = $clog2(NUM_W);
    localparam int CAND_W   = 20;
    localparam logic [31:0] CHI_MAX = 32'hFFFF_FFFF;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCAN_START  = 2'd0,
        CFG_SCAN_STEP   = 2'd1,
        CFG_SCAN_POINTS = 2'd2,
        CFG_MATCH_TOL   = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [12:0] hit_z;
        logic [10:0]        hit_r;
        logic [7:0]         cluster_width;
        logic               hit_present;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [12:0] vtx_pos;
        logic [10:0]        best_hit_count;
        logic               overflow;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CAND,
        S_READ,
        S_LOAD,
        S_DIV,
        S_ACC,
        S_EVAL,
        S_DONE
    } t_state;

endpackage

// File: rtl/cluster_width_vertex_scan.sv
// Hit items without last are taken while the block stays idle; busy stays low.
// The last item starts a scan: for each candidate every stored hit passes through store
// read, load, a 22-step shift-subtract divider and accumulate, while a zero-radius hit
// skips the divider and accumulate; the strobe rises after the last candidate is evaluated.
// An empty event or zero scan_points gives it in the next cycle, and the next item is
// taken in the cycle after the strobe. The receiver cannot stall it. Reset (synchronous,
// active low) clears the control state and loads the default config.
module cluster_width_vertex_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  cwvs_pkg::t_in       i_in,
    output logic                o_valid,
    output cwvs_pkg::t_out      o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data
);
    import cwvs_pkg::*;

    t_state r_state, n_state;

    logic signed [12:0] r_scan_start;
    logic [6:0]         r_scan_step;
    logic [10:0]        r_scan_points;
    logic [10:0]        r_match_tol;

    logic [CNT_W-1:0]   r_nhits;
    logic               r_ovf;
    logic [HIT_AW-1:0]  r_idx;
    logic [10:0]        r_k;
    logic signed [CAND_W-1:0] r_c;
    logic signed [12:0] r_z0;
    logic [CNT_W-1:0]   r_n;
    logic [31:0]        r_chi;
    logic [CNT_W-1:0]   r_best_n;
    logic [31:0]        r_best_chi;
    logic signed [12:0] r_best_pos;
    logic [NUM_W-1:0]   r_num;
    logic [10:0]        r_rem;
    logic [10:0]        r_div;
    logic [7:0]         r_w;
    logic [STEP_W-1:0]  r_step;

    logic               accept;
    logic               store_we;
    logic [HIT_W-1:0]   rd_data;
    logic signed [12:0] rd_z;
    logic [10:0]        rd_r;
    logic [7:0]         rd_w;
    logic signed [13:0] dz;
    logic [12:0]        adz;
    logic [11:0]        rem2;
    logic               q_bit;
    logic [23:0]        p_val;
    logic [23:0]        w_val;
    logic [23:0]        dev;
    logic [32:0]        chi_sum;
    logic               last_hit;
    logic               last_cand;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign store_we    = accept && i_in.hit_present && (r_nhits < CNT_W'(MAX_HITS));

    cwvs_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_nhits[HIT_AW-1:0]),
        .i_wdata ({i_in.hit_z, i_in.hit_r, i_in.cluster_width}),
        .i_re    (r_state == S_READ),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    // stored word fields and hit distance to the candidate
    assign rd_z = rd_data[31:19];
    assign rd_r = rd_data[18:8];
    assign rd_w = rd_data[7:0];
    assign dz   = 14'(rd_z) - 14'(r_z0);
    assign adz  = dz[13] ? 13'(-dz) : dz[12:0];

    // one restoring divide step
    assign rem2  = {r_rem, r_num[NUM_W-1]};
    assign q_bit = (rem2 >= {1'b0, r_div});

    // deviation from measured width and saturating chi sum
    assign p_val   = 24'(r_num) + 24'd128;
    assign w_val   = {8'd0, r_w, 8'd0};
    assign dev     = (p_val > w_val) ? (p_val - w_val) : (w_val - p_val);
    assign chi_sum = {1'b0, r_chi} + 33'(dev);

    assign last_hit  = (CNT_W'(r_idx) == r_nhits - CNT_W'(1));
    assign last_cand = (r_k == r_scan_points - 11'd1);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.last) begin
                    if ((r_nhits == '0 && !store_we) || r_scan_points == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_CAND;
                    end
                end
            end
            S_CAND: n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                if (rd_r == '0) begin
                    n_state = last_hit ? S_EVAL : S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC:  n_state = last_hit ? S_EVAL : S_READ;
            S_EVAL: n_state = last_cand ? S_DONE : S_CAND;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_start  <= -13'sd2220;
            r_scan_step   <= 7'd10;
            r_scan_points <= 11'd445;
            r_match_tol   <= 11'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCAN_START:  r_scan_start  <= i_cfg_data;
                CFG_SCAN_STEP:   r_scan_step   <= i_cfg_data[6:0];
                CFG_SCAN_POINTS: r_scan_points <= i_cfg_data[10:0];
                CFG_MATCH_TOL:   r_match_tol   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // event fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nhits <= '0;
            r_ovf   <= 1'b0;
        end else if (r_state == S_DONE) begin
            r_nhits <= '0;
            r_ovf   <= 1'b0;
        end else if (accept && i_in.hit_present) begin
            if (store_we) begin
                r_nhits <= r_nhits + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_n   <= '0;
            r_best_chi <= CHI_MAX;
            r_best_pos <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in.last) begin
                        r_best_n   <= '0;
                        r_best_chi <= CHI_MAX;
                        r_best_pos <= '0;
                        r_k        <= '0;
                        r_c        <= CAND_W'(r_scan_start);
                    end
                end
                S_CAND: begin
                    r_z0  <= (r_c > CAND_W'(4095)) ? 13'sd4095 : r_c[12:0];
                    r_idx <= '0;
                    r_n   <= '0;
                    r_chi <= '0;
                end
                S_LOAD: begin
                    r_num  <= {adz, 9'd0};
                    r_rem  <= '0;
                    r_div  <= rd_r;
                    r_w    <= rd_w;
                    r_step <= '0;
                    if (rd_r == '0 && !last_hit) begin
                        r_idx <= r_idx + HIT_AW'(1);
                    end
                end
                S_DIV: begin
                    r_rem  <= q_bit ? 11'(rem2 - {1'b0, r_div}) : rem2[10:0];
                    r_num  <= {r_num[NUM_W-2:0], q_bit};
                    r_step <= r_step + STEP_W'(1);
                end
                S_ACC: begin
                    if (dev <= 24'(r_match_tol)) begin
                        r_chi <= chi_sum[32] ? CHI_MAX : chi_sum[31:0];
                        r_n   <= r_n + CNT_W'(1);
                    end
                    if (!last_hit) begin
                        r_idx <= r_idx + HIT_AW'(1);
                    end
                end
                S_EVAL: begin
                    if (r_n != '0) begin
                        if (r_n > r_best_n) begin
                            r_best_n <= r_n;
                            if (r_chi != CHI_MAX) begin
                                r_best_chi <= r_chi;
                                r_best_pos <= r_z0;
                            end else begin
                                r_best_chi <= CHI_MAX;
                            end
                        end else if (r_n == r_best_n && r_chi < r_best_chi) begin
                            r_best_chi <= r_chi;
                            r_best_pos <= r_z0;
                        end
                    end
                    r_k <= r_k + 11'd1;
                    r_c <= r_c + CAND_W'(r_scan_step);
                end
                default: ;
            endcase
        end
    end

    // result word
    assign o_valid              = (r_state == S_DONE);
    assign o_res.vtx_pos        = r_best_pos;
    assign o_res.best_hit_count = r_best_n;
    assign o_res.overflow       = r_ovf;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy after result");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nhits <= CNT_W'(MAX_HITS))
        else $error("fill count beyond store");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div != '0))
        else $error("divide by zero radius");
    a_best_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_best_n == '0) |-> (r_best_pos == '0))
        else $error("position without counted hits");
endmodule

// File: rtl/cwvs_ram.sv
module cwvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import cwvs_pkg::*;

    localparam int CLK_HALF = 6;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in        i_in;
    logic       o_valid;
    t_out       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [12:0] i_cfg_data;

    cluster_width_vertex_scan dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the configuration and hit store
    int          scan_start_m;
    int unsigned scan_step_m;
    int unsigned scan_points_m;
    int unsigned tol_m;
    int          hit_z_m [MAX_HITS];
    int unsigned hit_r_m [MAX_HITS];
    int unsigned hit_w_m [MAX_HITS];
    int unsigned hits_held;
    bit          hits_lost;

    t_in  pend_q[$];
    t_out vertex_q[$];
    int   errors;
    int   events_done;
    int   words_sent;
    int   gap_left;
    bit   no_idle;
    bit   item_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // scan all candidates over the held hits and form the expected word
    function automatic t_out scan_vertex();
        t_out        res;
        longint      cand;
        longint      adz;
        longint      pw;
        longint      mw;
        longint      dev;
        longint      chi;
        longint      best_chi;
        int unsigned n;
        int unsigned best_n;
        int          best_z;
        int          z0;
        best_n   = 0;
        best_chi = 64'hFFFF_FFFF;
        best_z   = 0;
        for (int k = 0; k < scan_points_m; k++) begin
            cand = longint'(scan_start_m) + longint'(k) * longint'(scan_step_m);
            z0 = (cand > 4095) ? 4095 : int'(cand);
            n = 0;
            chi = 0;
            for (int i = 0; i < hits_held; i++) begin
                if (hit_r_m[i] == 0) continue;
                adz = hit_z_m[i] - z0;
                if (adz < 0) adz = -adz;
                pw = (2 * adz * 256) / hit_r_m[i] + 128;
                mw = longint'(hit_w_m[i]) * 256;
                dev = (pw > mw) ? pw - mw : mw - pw;
                if (dev <= tol_m) begin
                    chi += dev;
                    if (chi > 64'hFFFF_FFFF) chi = 64'hFFFF_FFFF;
                    n++;
                end
            end
            if (n == 0) continue;
            if (n > best_n) begin
                best_n   = n;
                best_chi = 64'hFFFF_FFFF;
            end
            if (n >= best_n && chi < best_chi) begin
                best_chi = chi;
                best_z   = z0;
            end
        end
        res.vtx_pos        = best_z[12:0];
        res.best_hit_count = (best_n > 2047) ? 11'd2047 : best_n[10:0];
        res.overflow       = hits_lost;
        return res;
    endfunction

    // word acceptance, prediction and result check
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (!i_rst_n) begin
            item_taken <= 1'b0;
        end else begin
            item_taken <= start && !busy;
            if (start && !busy) begin
                words_sent++;
                if (i_in.hit_present) begin
                    if (hits_held < MAX_HITS) begin
                        hit_z_m[hits_held] = i_in.hit_z;
                        hit_r_m[hits_held] = i_in.hit_r;
                        hit_w_m[hits_held] = i_in.cluster_width;
                        hits_held++;
                    end else begin
                        hits_lost = 1'b1;
                    end
                end
                if (i_in.last) begin
                    vertex_q = {vertex_q, scan_vertex()};
                    hits_held = 0;
                    hits_lost = 1'b0;
                end
            end
            if (o_valid) begin
                got = o_res;
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, got);
                    errors++;
                end else begin
                    want = vertex_q.pop_front();
                    events_done++;
                    if (got.vtx_pos !== want.vtx_pos) begin
                        $display("%0t: vtx_pos expected %0d actual %0d",
                                 $time, want.vtx_pos, got.vtx_pos);
                        errors++;
                    end
                    if (got.best_hit_count !== want.best_hit_count) begin
                        $display("%0t: best_hit_count expected %0d actual %0d",
                                 $time, want.best_hit_count, got.best_hit_count);
                        errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.overflow, got.overflow);
                        errors++;
                    end
                end
            end
        end
    end

    // driver: next word from the pending queue at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_in     <= '0;
            gap_left <= 0;
        end else if (!start || item_taken) begin
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!no_idle && start && $urandom_range(0, 5) == 0) begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 6);
            end else if (pend_q.size() != 0) begin
                i_in  <= pend_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic write_cfg(input t_cfg_index idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCAN_START:  scan_start_m  = $signed(val);
            CFG_SCAN_STEP:   scan_step_m   = val[6:0];
            CFG_SCAN_POINTS: scan_points_m = val[10:0];
            CFG_MATCH_TOL:   tol_m         = val[10:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_scan(input int s0, input int st, input int np, input int tl);
        write_cfg(CFG_SCAN_START, s0[12:0]);
        write_cfg(CFG_SCAN_STEP, st[12:0]);
        write_cfg(CFG_SCAN_POINTS, np[12:0]);
        write_cfg(CFG_MATCH_TOL, tl[12:0]);
    endtask

    // block until every word is taken and every result is in
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || start || vertex_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic push_word(input int z, input int r, input int w,
                             input bit hit, input bit fin);
        t_in wd;
        wd.hit_z         = z[12:0];
        wd.hit_r         = r[10:0];
        wd.cluster_width = w[7:0];
        wd.hit_present   = hit;
        wd.last          = fin;
        pend_q = {pend_q, wd};
    endtask

    // one event: mostly hits that point back at a common vertex
    task automatic push_event(input int nhits);
        int v;
        int z;
        int r;
        int w;
        int adz;
        bit closed;
        closed = 1'b0;
        v = $urandom_range(0, 6000) - 3000;
        for (int i = 0; i < nhits; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                z = $urandom_range(0, 6000) - 3000;
                r = $urandom_range(1, 2000);
                adz = (z > v) ? z - v : v - z;
                w = (2 * adz) / r + $urandom_range(0, 1) - 1;
                if (w < 0) w = 0;
                if (w > 255) w = 255;
            end else begin
                z = $urandom_range(0, 8191) - 4096;
                r = $urandom_range(0, 2047);
                w = $urandom_range(0, 255);
            end
            if ($urandom_range(0, 15) == 0)
                push_word(z, r, w, 1'b0, 1'b0);
            closed = (i == nhits - 1) && ($urandom_range(0, 1) != 0);
            push_word(z, r, w, 1'b1, closed);
        end
        if (!closed)
            push_word($urandom_range(0, 8191), $urandom_range(0, 2047),
                      $urandom_range(0, 255), 1'b0, 1'b1);
    endtask

    // stimulus
    initial begin
        int phase_words;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        errors        = 0;
        events_done   = 0;
        words_sent    = 0;
        no_idle       = 1'b0;
        hits_held     = 0;
        hits_lost     = 1'b0;
        scan_start_m  = -2220;
        scan_step_m   = 10;
        scan_points_m = 445;
        tol_m         = 256;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: empty event, stray word, hits with last on a hit
        push_word(0, 0, 0, 1'b0, 1'b1);
        push_word(123, 77, 9, 1'b0, 1'b0);
        push_word(0, 500, 0, 1'b1, 1'b0);
        push_word(-4096, 2047, 255, 1'b1, 1'b0);
        push_word(4095, 0, 7, 1'b1, 1'b0);
        push_word(400, 800, 2, 1'b1, 1'b1);
        wait_drained();

        // empty scan range
        set_scan(0, 1, 0, 1024);
        push_word(100, 100, 1, 1'b1, 1'b1);
        wait_drained();

        // candidates running past the top of the z range
        set_scan(3000, 100, 1024, 2047);
        push_word(4095, 1, 0, 1'b1, 1'b0);
        push_word(3500, 2000, 1, 1'b1, 1'b1);
        wait_drained();

        // widest settings, zero tolerance
        set_scan(-4096, 127, 2047, 0);
        push_word(-4096, 1024, 0, 1'b1, 1'b1);
        wait_drained();

        // full store: two hits past capacity are dropped
        set_scan(-50, 50, 2, 512);
        for (int i = 0; i < MAX_HITS + 2; i++)
            push_word($urandom_range(0, 200) - 100, $urandom_range(1, 2047),
                      $urandom_range(0, 3), 1'b1, i == MAX_HITS + 1);
        wait_drained();

        // random phases, each with a fresh setting
        for (int ph = 0; ph < 8; ph++) begin
            no_idle = (ph == 7);
            set_scan($urandom_range(0, 8191) - 4096, $urandom_range(0, 127),
                     $urandom_range(1, 24), $urandom_range(0, 2047));
            phase_words = words_sent + pend_q.size();
            while (words_sent + pend_q.size() - phase_words < 14) begin
                push_event($urandom_range(0, 6));
                while (pend_q.size() > 8) @(posedge i_clk);
            end
            wait_drained();
        end

        $display("ran %0d input words over %0d events, checked %0d vertex results",
                 words_sent, events_done, events_done);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(2 * CLK_HALF * 4_000_000);
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/cwvs_pkg.sv
rtl/cwvs_ram.sv
rtl/cluster_width_vertex_scan.sv
dv/tb.sv
